FILE: hw/rtl/arpnc_pkg.sv
// Shared types, codes and helper functions for the address resolution cache.
package arpnc_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_EVAL,
      S_ACT
   } state_type;

   // Request function codes.
   localparam logic [1:0] FN_FETCH = 2'd0;
   localparam logic [1:0] FN_MERGE = 2'd1;
   localparam logic [1:0] FN_SCAN  = 2'd2;
   localparam logic [1:0] FN_NOP   = 2'd3;

   // Entry state codes.
   localparam logic [2:0] ST_UNUSED     = 3'd0;
   localparam logic [2:0] ST_REQUESTED  = 3'd1;
   localparam logic [2:0] ST_COOLDOWN   = 3'd2;
   localparam logic [2:0] ST_CONTENDED  = 3'd3;
   localparam logic [2:0] ST_REFRESHING = 3'd4;
   localparam logic [2:0] ST_VALID      = 3'd7;

   // Response status codes.
   localparam logic [2:0] RS_RESOLVED  = 3'd0;
   localparam logic [2:0] RS_PENDING   = 3'd1;
   localparam logic [2:0] RS_NEW       = 3'd2;
   localparam logic [2:0] RS_BCAST     = 3'd3;
   localparam logic [2:0] RS_MERGED    = 3'd4;
   localparam logic [2:0] RS_DROPPED   = 3'd5;
   localparam logic [2:0] RS_IDLE_DONE = 3'd6;

   // Configuration register indexes.
   localparam logic [2:0] CSR_COOLDOWN  = 3'd0;
   localparam logic [2:0] CSR_REFRESH   = 3'd1;
   localparam logic [2:0] CSR_KEEP_CONT = 3'd2;
   localparam logic [2:0] CSR_INVALID   = 3'd3;
   localparam logic [2:0] CSR_RETRY_INI = 3'd4;
   localparam logic [2:0] CSR_BACKOFF   = 3'd5;
   localparam logic [2:0] CSR_SUBNET_BC = 3'd6;

   // Configuration reset values.
   localparam logic [15:0] RST_COOLDOWN  = 16'd50;
   localparam logic [31:0] RST_REFRESH   = 32'd5000;
   localparam logic [31:0] RST_KEEP_CONT = 32'd300000;
   localparam logic [31:0] RST_INVALID   = 32'd3600000;
   localparam logic [9:0]  RST_RETRY_INI = 10'd1;
   localparam logic [3:0]  RST_BACKOFF   = 4'd10;

   // Fixed constants.
   localparam logic [19:0] HASH_PRIME = 20'd939193;
   localparam logic [15:0] IMP_MAX    = 16'd32767;
   localparam logic [47:0] MAC_ALL    = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] IP_ALL     = 32'hFFFF_FFFF;

   // One cache entry as stored in the table.
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [2:0]  state;
      logic [3:0]  backoff;
      logic [15:0] importance;
      logic [31:0] last_seen;
      logic [31:0] last_change;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Apply timeouts and state promotions to one entry.
   function automatic entry_type age_entry(
      input entry_type   e,
      input logic [31:0] now,
      input logic [15:0] cooldown,
      input logic [31:0] refresh,
      input logic [31:0] keep_cont,
      input logic [31:0] invalid
   );
      entry_type   r;
      logic [31:0] age;
      logic [31:0] since;
      r     = e;
      age   = now - e.last_seen;
      since = now - e.last_change;
      if (e.state != ST_UNUSED) begin
         if ((e.state == ST_CONTENDED && age >= keep_cont) || age >= invalid) begin
            r = '0;
         end else begin
            if (e.state == ST_COOLDOWN && since >= {16'd0, cooldown}) begin
               r.state = ST_VALID;
            end
            if (r.state == ST_VALID && age >= refresh) begin
               r.state = ST_REFRESHING;
            end
         end
      end
      return r;
   endfunction

   // Eviction class: 0 means the slot is free.
   function automatic logic [1:0] evict_class(input logic [2:0] st);
      logic [1:0] c;
      case (st)
         ST_VALID, ST_REFRESHING: c = 2'd1;
         ST_REQUESTED, ST_COOLDOWN: c = 2'd2;
         ST_CONTENDED: c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/arpnc_if.sv
// Handshake channel interfaces for requests, responses and register writes.
interface arpnc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] now_time;
   logic [31:0] lookup_ip;
   logic [31:0] own_ip;
   logic [47:0] seen_mac;
   logic        permissive;

   modport source (output valid, func, now_time, lookup_ip, own_ip, seen_mac, permissive,
                   input ready);
   modport sink (input valid, func, now_time, lookup_ip, own_ip, seen_mac, permissive,
                 output ready);
endinterface

interface arpnc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [47:0] mac_out;
   logic        send_request;
   logic [31:0] request_target_ip;
   logic [31:0] request_sender_ip;

   modport source (output valid, status, mac_out, send_request, request_target_ip,
                   request_sender_ip, input ready);
   modport sink (input valid, status, mac_out, send_request, request_target_ip,
                 request_sender_ip, output ready);
endinterface

interface arpnc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

FILE: hw/rtl/arp_neighbor_cache.sv
// Address resolution cache: hashed neighbourhood table with aging and eviction.
//
// Requests arrive on req_chan (fetch, merge, scan tick or no operation) and
// each one produces exactly one response on rsp_chan. Register writes arrive
// on csr_chan, are always ready and take effect at once; write them only
// while no request is in flight.
// A fetch hashes the address with one 32x20 multiply, then walks the
// neighbourhood one slot at a time through the single table RAM: each slot
// is read, then aged, written back and ranked. The walk stops at a match.
// A fetch or merge visits at most NEIGHBOURHOOD slots (8 at the default), a
// scan tick reads one slot, and a broadcast fetch or no operation none.
// The block takes one request at a time; req_chan.ready is high only when
// the sequencer is idle.
// After reset the table is cleared one entry per cycle, all 2**INDEX_BITS
// entries (1024 at the default), and no request is taken meanwhile.
// A response waits in its output register while the receiver stalls; the
// block finishes the request and takes the next one only once it is free.
module arp_neighbor_cache
   import arpnc_pkg::*;
#(
   parameter int INDEX_BITS    = 10,
   parameter int NEIGHBOURHOOD = 8
) (
   input logic        clock,
   input logic        reset,
   arpnc_req_if.sink  req_chan,
   arpnc_rsp_if.source rsp_chan,
   arpnc_csr_if.sink  csr_chan
);

   localparam int SLOTS = 1 << INDEX_BITS;
   localparam int CNT_W = (NEIGHBOURHOOD > 1) ? $clog2(NEIGHBOURHOOD) : 1;

   // Sequencer and control registers.
   state_type             state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_ff, clr_in;
   logic [INDEX_BITS-1:0] scan_ff, scan_in;
   logic [INDEX_BITS-1:0] slot_ff, slot_in;
   logic [INDEX_BITS-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic                  free_ff, free_in;
   logic                  have_ff, have_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Request payload and walk data.
   logic [1:0]  func_ff, func_in;
   logic        bcast_ff, bcast_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] ip_ff, ip_in;
   logic [31:0] own_ff, own_in;
   logic [47:0] mac_ff, mac_in;
   logic        perm_ff, perm_in;
   entry_type   rec_ff, rec_in;
   logic [1:0]  best_cls_ff, best_cls_in;
   logic [15:0] best_imp_ff, best_imp_in;
   logic [31:0] best_age_ff, best_age_in;

   // Response payload.
   logic [2:0]  status_ff, status_in;
   logic [47:0] mac_out_ff, mac_out_in;
   logic        send_ff, send_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [31:0] snd_ff, snd_in;

   // Configuration registers.
   logic [15:0] cooldown_ff;
   logic [31:0] refresh_ff;
   logic [31:0] keep_cont_ff;
   logic [31:0] invalid_ff;
   logic [9:0]  retry_ini_ff;
   logic [3:0]  backoff_max_ff;
   logic [31:0] subnet_bc_ff;

   // Table RAM port signals.
   logic                  ram_we;
   logic [INDEX_BITS-1:0] ram_waddr;
   entry_type             ram_wdata;
   entry_type             ram_rdata;
   logic [ENTRY_W-1:0]    ram_rdata_raw;

   // Combinational helpers.
   logic        req_fire;
   logic        req_bcast;
   logic        rsp_free;
   logic        last_slot;
   logic [51:0] hash_prod;
   entry_type   aged;
   logic        is_match;
   logic [1:0]  cand_cls;
   logic [31:0] cand_age;
   logic        keep_best;
   entry_type   act_rec;
   logic [2:0]  act_status;
   logic [47:0] act_mac;
   logic        act_send;
   logic        act_we;
   logic [31:0] act_wait;
   logic [24:0] lim_entry;
   logic [24:0] lim_max;

   arpnc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (slot_ff),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   // Handshake terms.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign req_bcast      = (req_chan.func == FN_FETCH) &&
                           (req_chan.lookup_ip == IP_ALL || req_chan.lookup_ip == subnet_bc_ff);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign last_slot      = (cnt_ff == CNT_W'(NEIGHBOURHOOD - 1));
   assign csr_chan.ready = 1'b1;

   // Hash of the address: prime multiply, top bits of the low word.
   assign hash_prod = 52'(ip_ff) * 52'(HASH_PRIME);

   // Aging and ranking of the slot that the RAM just returned.
   assign aged     = age_entry(ram_rdata, now_ff, cooldown_ff, refresh_ff, keep_cont_ff,
                               invalid_ff);
   assign is_match = (aged.ip == ip_ff) && (aged.state != ST_UNUSED);
   assign cand_cls = evict_class(aged.state);
   assign cand_age = now_ff - aged.last_seen;

   always_comb begin
      keep_best = 1'b0;
      if (have_ff) begin
         if (aged.importance == 16'd0) begin
            keep_best = (best_imp_ff == 16'd0) && (cand_age >= best_age_ff);
         end else if (cand_cls > best_cls_ff) begin
            keep_best = 1'b1;
         end else if (cand_cls == best_cls_ff) begin
            keep_best = (aged.importance > best_imp_ff) ||
                        (aged.importance == best_imp_ff && cand_age >= best_age_ff);
         end
      end
   end

   // Final action on the selected entry.
   assign act_wait  = now_ff - rec_ff.last_change;
   assign lim_entry = 25'(retry_ini_ff) << rec_ff.backoff;
   assign lim_max   = 25'(retry_ini_ff) << backoff_max_ff;

   always_comb begin
      act_rec    = rec_ff;
      act_status = RS_IDLE_DONE;
      act_mac    = '0;
      act_send   = 1'b0;
      act_we     = 1'b0;
      if (bcast_ff) begin
         act_status = RS_BCAST;
         act_mac    = MAC_ALL;
      end else begin
         case (func_ff)
            FN_FETCH: begin
               act_we = 1'b1;
               if (found_ff) begin
                  act_status = RS_PENDING;
                  if (rec_ff.state == ST_REQUESTED) begin
                     if (act_wait > {7'd0, lim_entry}) begin
                        act_send            = 1'b1;
                        act_rec.last_change = now_ff;
                        if (rec_ff.backoff < backoff_max_ff) begin
                           act_rec.backoff = rec_ff.backoff + 4'd1;
                        end
                     end
                  end else if (rec_ff.state == ST_COOLDOWN || rec_ff.state == ST_CONTENDED ||
                               rec_ff.state == ST_REFRESHING || rec_ff.state == ST_VALID) begin
                     if (perm_ff || rec_ff.state == ST_REFRESHING ||
                         rec_ff.state == ST_VALID) begin
                        if (rec_ff.state == ST_REFRESHING && act_wait > {7'd0, lim_max}) begin
                           act_send            = 1'b1;
                           act_rec.last_change = now_ff;
                        end
                        act_mac = rec_ff.mac;
                        if (rec_ff.importance < IMP_MAX) begin
                           act_rec.importance = rec_ff.importance + 16'd1;
                        end
                        act_status = RS_RESOLVED;
                     end
                  end
               end else begin
                  act_rec.ip          = ip_ff;
                  act_rec.mac         = MAC_ALL;
                  act_rec.state       = ST_REQUESTED;
                  act_rec.backoff     = '0;
                  act_rec.importance  = 16'd1;
                  act_rec.last_seen   = now_ff;
                  act_rec.last_change = now_ff;
                  act_send            = 1'b1;
                  act_status          = RS_NEW;
               end
            end
            FN_MERGE: begin
               act_we     = 1'b1;
               act_status = RS_MERGED;
               if (rec_ff.state != ST_UNUSED && rec_ff.ip != ip_ff) begin
                  if (rec_ff.importance != 16'd0 || rec_ff.state == ST_CONTENDED) begin
                     act_status = RS_DROPPED;
                  end else begin
                     act_rec = '0;
                  end
               end
               if (act_status == RS_MERGED) begin
                  if (act_rec.state == ST_UNUSED) begin
                     act_rec.ip          = ip_ff;
                     act_rec.mac         = mac_ff;
                     act_rec.state       = ST_COOLDOWN;
                     act_rec.backoff     = '0;
                     act_rec.importance  = '0;
                     act_rec.last_seen   = now_ff;
                     act_rec.last_change = now_ff;
                  end else begin
                     act_rec.last_seen = now_ff;
                     if (rec_ff.state == ST_REQUESTED) begin
                        act_rec.state = ST_COOLDOWN;
                        act_rec.mac   = mac_ff;
                     end else if (mac_ff != rec_ff.mac) begin
                        act_rec.state       = ST_CONTENDED;
                        act_rec.last_change = now_ff;
                     end else if (rec_ff.state == ST_REFRESHING) begin
                        act_rec.state = ST_VALID;
                     end
                  end
               end
            end
            FN_SCAN: begin
               act_we = 1'b1;
               if ((rec_ff.state == ST_REQUESTED || rec_ff.state == ST_VALID ||
                    rec_ff.state == ST_CONTENDED) && rec_ff.importance > 16'd1) begin
                  act_rec.importance = {1'b0, rec_ff.importance[15:1]};
               end
            end
            default: begin
               act_status = RS_IDLE_DONE;
            end
         endcase
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == INDEX_BITS'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FN_NOP || req_bcast) begin
                  state_in = S_ACT;
               end else if (req_chan.func == FN_SCAN) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: state_in = S_READ;
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (func_ff == FN_SCAN || is_match || last_slot) begin
               state_in = S_ACT;
            end else begin
               state_in = S_READ;
            end
         end
         S_ACT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Datapath and output logic.
   always_comb begin
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      slot_in      = slot_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      have_in      = have_ff;
      func_in      = func_ff;
      bcast_in     = bcast_ff;
      now_in       = now_ff;
      ip_in        = ip_ff;
      own_in       = own_ff;
      mac_in       = mac_ff;
      perm_in      = perm_ff;
      rec_in       = rec_ff;
      best_cls_in  = best_cls_ff;
      best_imp_in  = best_imp_ff;
      best_age_in  = best_age_ff;
      status_in    = status_ff;
      mac_out_in   = mac_out_ff;
      send_in      = send_ff;
      tgt_in       = tgt_ff;
      snd_in       = snd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_we       = 1'b0;
      ram_waddr    = slot_ff;
      ram_wdata    = aged;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + INDEX_BITS'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_chan.func;
               bcast_in = req_bcast;
               now_in   = req_chan.now_time;
               ip_in    = req_chan.lookup_ip;
               own_in   = req_chan.own_ip;
               mac_in   = req_chan.seen_mac;
               perm_in  = req_chan.permissive;
               slot_in  = scan_ff;
               cnt_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               have_in  = 1'b0;
            end
         end
         S_HASH: begin
            slot_in = hash_prod[31 -: INDEX_BITS];
         end
         S_READ: begin
            slot_in = slot_ff;
         end
         S_EVAL: begin
            // Write the aged entry back, then decide on match or eviction rank.
            ram_we  = 1'b1;
            slot_in = slot_ff + INDEX_BITS'(1);
            cnt_in  = cnt_ff + CNT_W'(1);
            if (func_ff == FN_SCAN) begin
               rec_in = aged;
               sel_in = slot_ff;
            end else if (is_match) begin
               found_in = 1'b1;
               rec_in   = aged;
               sel_in   = slot_ff;
            end else if (!free_ff) begin
               if (cand_cls == 2'd0) begin
                  free_in = 1'b1;
                  rec_in  = aged;
                  sel_in  = slot_ff;
               end else if (!keep_best) begin
                  have_in     = 1'b1;
                  rec_in      = aged;
                  sel_in      = slot_ff;
                  best_cls_in = cand_cls;
                  best_imp_in = aged.importance;
                  best_age_in = cand_age;
               end
            end
         end
         S_ACT: begin
            // Commit the entry and load the response once the output is free.
            if (rsp_free) begin
               ram_we       = act_we;
               ram_waddr    = sel_ff;
               ram_wdata    = act_rec;
               rsp_valid_in = 1'b1;
               status_in    = act_status;
               mac_out_in   = act_mac;
               send_in      = act_send;
               tgt_in       = act_send ? ip_ff : 32'd0;
               snd_in       = act_send ? own_ff : 32'd0;
               if (func_ff == FN_SCAN) begin
                  scan_in = scan_ff + INDEX_BITS'(1);
               end
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         have_ff      <= have_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      sel_ff      <= sel_in;
      func_ff     <= func_in;
      bcast_ff    <= bcast_in;
      now_ff      <= now_in;
      ip_ff       <= ip_in;
      own_ff      <= own_in;
      mac_ff      <= mac_in;
      perm_ff     <= perm_in;
      rec_ff      <= rec_in;
      best_cls_ff <= best_cls_in;
      best_imp_ff <= best_imp_in;
      best_age_ff <= best_age_in;
      status_ff   <= status_in;
      mac_out_ff  <= mac_out_in;
      send_ff     <= send_in;
      tgt_ff      <= tgt_in;
      snd_ff      <= snd_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_ff    <= RST_COOLDOWN;
         refresh_ff     <= RST_REFRESH;
         keep_cont_ff   <= RST_KEEP_CONT;
         invalid_ff     <= RST_INVALID;
         retry_ini_ff   <= RST_RETRY_INI;
         backoff_max_ff <= RST_BACKOFF;
         subnet_bc_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_COOLDOWN:  cooldown_ff    <= csr_chan.data[15:0];
            CSR_REFRESH:   refresh_ff     <= csr_chan.data;
            CSR_KEEP_CONT: keep_cont_ff   <= csr_chan.data;
            CSR_INVALID:   invalid_ff     <= csr_chan.data;
            CSR_RETRY_INI: retry_ini_ff   <= csr_chan.data[9:0];
            CSR_BACKOFF:   backoff_max_ff <= csr_chan.data[3:0];
            CSR_SUBNET_BC: subnet_bc_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Response channel.
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.mac_out           = mac_out_ff;
   assign rsp_chan.send_request      = send_ff;
   assign rsp_chan.request_target_ip = tgt_ff;
   assign rsp_chan.request_sender_ip = snd_ff;

`ifndef NO_ASSERTIONS
   // No request is taken while the table is being cleared.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("request ready during table clear");

   // An accepted request always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after accepting a request");

   // The walk never runs past the neighbourhood.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (cnt_ff <= CNT_W'(NEIGHBOURHOOD - 1)))
      else $error("neighbourhood walk overran");

   // A response is loaded only when leaving the action step.
   a_rsp_from_act: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_ACT))
      else $error("response raised outside the action step");
`endif

endmodule

FILE: hw/rtl/arpnc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module arpnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
